// ----- rtl/core/hcm37_pkg.sv -----
package hcm37_pkg;

   localparam int MAX_BLOCK = 7;
   localparam int HW_ROWS   = 7;
   localparam int LIM_ROWS  = (MAX_BLOCK < HW_ROWS) ? MAX_BLOCK : HW_ROWS;

   localparam int CHAR_W  = 8;
   localparam int SYM_W   = 6;
   localparam int CNT_W   = 3;
   localparam int BSZ_W   = 3;
   localparam int KEY_W   = SYM_W * HW_ROWS;
   localparam int CSR_W   = KEY_W;
   localparam int IDX_W   = 3;
   localparam int PROD_W  = 2 * SYM_W;
   localparam int SUM_W   = 15;
   localparam int QUO_W   = 10;

   localparam logic [SYM_W-1:0] PAD_SYMBOL = 6'd36;
   localparam logic [SYM_W-1:0] DIGIT_BASE = 6'd26;
   localparam int               MODULUS    = 37;

   // floor(s / 37) == (s * RECIP) >> RECIP_SHIFT for every s below 2**SUM_W
   localparam int RECIP_SHIFT = 21;
   localparam logic [16:0] RECIP = 17'd56680;
   localparam int QPROD_W = SUM_W + 17;

   localparam logic [IDX_W-1:0] CSR_BLOCK_SIZE = 3'd0;
   localparam logic [IDX_W-1:0] CSR_KEY_ROW_0  = 3'd1;
   localparam logic [IDX_W-1:0] CSR_KEY_ROW_6  = 3'd7;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DOT  = 5'b00010,
      ST_QUO  = 5'b00100,
      ST_RES  = 5'b01000,
      ST_SEND = 5'b10000
   } state_type;

   typedef struct packed {
      logic take;
      logic dot;
      logic quo;
      logic res;
      logic next_row;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic close;
      logic last_row;
   } status_type;

   function automatic logic [SYM_W:0] char_to_sym(input logic [CHAR_W-1:0] ch);
      logic [SYM_W:0] r;
      r = '0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         r = {1'b1, 6'(ch - 8'h41)};
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         r = {1'b1, 6'(ch - 8'h30) + DIGIT_BASE};
      end else if (ch == 8'h20) begin
         r = {1'b1, PAD_SYMBOL};
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] sym_to_char(input logic [SYM_W-1:0] s);
      logic [CHAR_W-1:0] r;
      if (s < DIGIT_BASE) begin
         r = 8'h41 + {2'b00, s};
      end else if (s < PAD_SYMBOL) begin
         r = 8'h30 + {2'b00, s - DIGIT_BASE};
      end else begin
         r = 8'h20;
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/hcm37_ctrl.sv -----
module hcm37_ctrl
   import hcm37_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall,
   output logic       rsp_valid
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (status.close) begin
                  state_in = ST_DOT;
               end
            end
         end
         ST_DOT: begin
            cmd.dot  = 1'b1;
            state_in = ST_QUO;
         end
         ST_QUO: begin
            cmd.quo  = 1'b1;
            state_in = ST_RES;
         end
         ST_RES: begin
            cmd.res  = 1'b1;
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (!rsp_stall) begin
               if (status.last_row) begin
                  cmd.done = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_row = 1'b1;
                  state_in     = ST_DOT;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_SEND);

endmodule

// ----- rtl/core/hcm37_dp.sv -----
module hcm37_dp
   import hcm37_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   input  logic [CHAR_W-1:0] req_in_char,
   input  logic              req_end_of_message,
   input  cmd_type           cmd,
   output status_type        status,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_last_of_block,
   output logic              rsp_last_of_message
);

   logic [BSZ_W-1:0] bsz_ff, bsz_in;
   logic [KEY_W-1:0] key_ff [HW_ROWS];
   logic [KEY_W-1:0] key_in [HW_ROWS];
   logic [SYM_W-1:0] sym_ff [HW_ROWS];
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] scnt_ff, scnt_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic             eom_ff, eom_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic             lob_ff, lob_in;
   logic             lom_ff, lom_in;

   logic [CNT_W-1:0]   n_eff;
   logic [CNT_W-1:0]   pos_next;
   logic [SYM_W:0]     dec;
   logic [KEY_W-1:0]   key_row;
   logic [SYM_W-1:0]   vec_c;
   logic [QPROD_W-1:0] qprod;
   logic [SUM_W-1:0]   rem;

   always_comb begin
      if (bsz_ff == '0) begin
         n_eff = CNT_W'(1);
      end else if (bsz_ff > CNT_W'(LIM_ROWS)) begin
         n_eff = CNT_W'(LIM_ROWS);
      end else begin
         n_eff = bsz_ff;
      end
   end

   assign dec = char_to_sym(req_in_char);

   // config registers
   always_comb begin
      bsz_in = bsz_ff;
      for (int r = 0; r < HW_ROWS; r++) begin
         key_in[r] = key_ff[r];
      end
      if (csr_we) begin
         if (csr_index == CSR_BLOCK_SIZE) begin
            bsz_in = csr_data[BSZ_W-1:0];
         end else if (csr_index >= CSR_KEY_ROW_0 && csr_index <= CSR_KEY_ROW_6) begin
            key_in[csr_index - CSR_KEY_ROW_0] = csr_data[KEY_W-1:0];
         end
      end
   end

   // position count after the current beat, saturating
   assign pos_next = (pos_ff < CNT_W'(HW_ROWS)) ? pos_ff + 1'b1 : pos_ff;

   // counts and block close
   always_comb begin
      pos_in  = pos_ff;
      scnt_in = scnt_ff;
      eom_in  = eom_ff;
      if (cmd.take) begin
         pos_in = pos_next;
         if (dec[SYM_W] && scnt_ff < CNT_W'(HW_ROWS)) begin
            scnt_in = scnt_ff + 1'b1;
         end
         eom_in = req_end_of_message;
      end else if (cmd.done) begin
         pos_in  = '0;
         scnt_in = '0;
      end
   end

   assign status.close    = (pos_next >= n_eff) || req_end_of_message;
   assign status.last_row = (row_ff == n_eff - 1'b1);

   assign key_row = key_ff[row_ff];

   always_comb begin
      row_in  = row_ff;
      sum_in  = sum_ff;
      quo_in  = quo_ff;
      char_in = char_ff;
      lob_in  = lob_ff;
      lom_in  = lom_ff;
      vec_c   = PAD_SYMBOL;
      qprod   = '0;
      rem     = '0;
      if (cmd.take || cmd.done) begin
         row_in = '0;
      end else if (cmd.next_row) begin
         row_in = row_ff + 1'b1;
      end
      if (cmd.dot) begin
         sum_in = '0;
         for (int c = 0; c < HW_ROWS; c++) begin
            vec_c = (CNT_W'(c) < scnt_ff) ? sym_ff[c] : PAD_SYMBOL;
            if (CNT_W'(c) < n_eff) begin
               sum_in = sum_in + SUM_W'(key_row[SYM_W*c +: SYM_W]) * SUM_W'(vec_c);
            end
         end
      end
      if (cmd.quo) begin
         qprod  = QPROD_W'(sum_ff) * QPROD_W'(RECIP);
         quo_in = qprod[RECIP_SHIFT +: QUO_W];
      end
      if (cmd.res) begin
         rem     = sum_ff - SUM_W'(quo_ff * SUM_W'(MODULUS));
         char_in = sym_to_char(rem[SYM_W-1:0]);
         lob_in  = status.last_row;
         lom_in  = status.last_row && eom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bsz_ff  <= BSZ_W'(1);
         pos_ff  <= '0;
         scnt_ff <= '0;
         row_ff  <= '0;
         for (int r = 0; r < HW_ROWS; r++) begin
            key_ff[r] <= '0;
         end
      end else begin
         bsz_ff  <= bsz_in;
         pos_ff  <= pos_in;
         scnt_ff <= scnt_in;
         row_ff  <= row_in;
         for (int r = 0; r < HW_ROWS; r++) begin
            key_ff[r] <= key_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && dec[SYM_W] && scnt_ff < CNT_W'(HW_ROWS)) begin
         sym_ff[scnt_ff] <= dec[SYM_W-1:0];
      end
      eom_ff  <= eom_in;
      sum_ff  <= sum_in;
      quo_ff  <= quo_in;
      char_ff <= char_in;
      lob_ff  <= lob_in;
      lom_ff  <= lom_in;
   end

   assign rsp_out_char        = char_ff;
   assign rsp_last_of_block   = lob_ff;
   assign rsp_last_of_message = lom_ff;

endmodule

// ----- rtl/core/hill_cipher_mod37.sv -----
// channel  ports                                              dir
// req      req_valid req_stall req_in_char req_end_of_message in
// rsp      rsp_valid rsp_stall rsp_out_char rsp_last_of_block  out
//          rsp_last_of_message
// csr      csr_we csr_index csr_data                          in
//
// A beat that does not close a block needs only the idle state. After a
// closing beat each of the n rows of the block runs the steps dot product,
// quotient, remainder and send in turn on the one shared row unit.
// Reset is synchronous and clears counts, block_size (to 1) and keys.
// rsp_stall holds the current row in place; req_stall is high while rows drain.
module hill_cipher_mod37
   import hcm37_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_we,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]  csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CHAR_W-1:0] req_in_char,
   input  logic              req_end_of_message,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_last_of_block,
   output logic              rsp_last_of_message
);

   cmd_type    cmd;
   status_type status;

   hcm37_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   hcm37_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_in_char         (req_in_char),
      .req_end_of_message  (req_end_of_message),
      .cmd                 (cmd),
      .status              (status),
      .rsp_out_char        (rsp_out_char),
      .rsp_last_of_block   (rsp_last_of_block),
      .rsp_last_of_message (rsp_last_of_message)
   );

endmodule
